### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the 1-wire search engine.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, held off while reset is high
`define OWSE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also runs through reset
`define OWSE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OWSE_ASSERT(label, clk, rst, prop, msg)
`define OWSE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### rtl/core/owse_pkg.sv
// Types and constants of the 1-wire search ROM engine.
// No dependencies; used by onewire_rom_search_engine_core.
`default_nettype none

package owse_pkg;

  localparam int unsigned ID_BITS     = 64;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 80;

  // first position past the end of the ID
  localparam logic [6:0] POS_END      = 7'd65;
  // positions below this lie in the family byte
  localparam logic [6:0] POS_FAMILY   = 7'd9;
  localparam logic [6:0] POS_FIRST    = 7'd1;
  // seeded last discrepancy for a targeted search
  localparam logic [6:0] TARGET_DISC  = 7'd64;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_PAIR   = 2'd1,
    FUNC_RESET  = 2'd2,
    FUNC_TARGET = 2'd3
  } func_t;

  // input tdata, lowest bit first from the bottom
  typedef struct packed {
    logic [7:0] family_code;
    logic       comp_bit;
    logic       id_bit;
    logic       presence;
  } in_item_t;

  // result item, lowest bit first from the bottom
  typedef struct packed {
    logic [3:0]  family_discrepancy;
    logic [63:0] device_id;
    logic        last_device;
    logic        found;
    logic        pass_done;
    logic        write_bit;
    logic        write_valid;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/onewire_rom_search_engine_core.sv
// 1-wire search ROM engine: bit-level decisions of the ROM enumeration.
// Depends on owse_pkg and assert_macros.svh.
//
// Usage: each input item (tuser = function) yields exactly one result item.
// An item is decided by logic on the registered search state; its result is
// registered, into the skid register if the result register is full and not
// taken. One item can be taken every cycle while s_tready is high. A two-entry
// output stage (result register plus skid register) keeps the slave side open
// while one result waits, so s_tready drops only when both entries are full.
// Bus timing and the command bytes are handled outside: for a bit pair with write_valid
// set, write_bit is the direction to drive. After reset the search state is clear and the ID zero.
`default_nettype none
`include "assert_macros.svh"

module onewire_rom_search_engine_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // [0] presence, [1] id_bit, [2] comp_bit, [10:3] family_code, rest zero
  input  wire logic [owse_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [1:0] func
  input  wire logic [1:0]                       s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [0] write_valid, [1] write_bit, [2] pass_done, [3] found,
  // [4] last_device, [68:5] device_id, [72:69] family_discrepancy, rest zero
  output logic [owse_pkg::OUT_TDATA_W-1:0]      m_tdata
);

  owse_pkg::in_item_t in_item;
  owse_pkg::func_t    func;
  owse_pkg::result_t  res;
  owse_pkg::result_t  out_reg;
  owse_pkg::result_t  skid_reg;
  logic               out_valid;
  logic               skid_valid;
  logic               acc;
  logic               take;

  // search state
  logic [63:0] id_register, id_register_next;
  logic [6:0]  last_discrepancy, last_discrepancy_next;
  logic [3:0]  last_family_disc, last_family_disc_next;
  logic        last_device_seen, last_device_seen_next;
  logic [6:0]  bit_position, bit_position_next;
  logic [6:0]  last_zero_pos, last_zero_pos_next;
  logic        pass_active, pass_active_next;

  logic wv, wb, done, found;

  assign in_item  = owse_pkg::in_item_t'(s_tdata[10:0]);
  assign func     = owse_pkg::func_t'(s_tuser);
  assign s_tready = !skid_valid;
  assign acc      = s_tvalid && s_tready;
  assign take     = m_tvalid && m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_reg};

  always_comb begin
    logic [6:0] pos;
    logic [5:0] sh;
    logic       dir;
    id_register_next      = id_register;
    last_discrepancy_next = last_discrepancy;
    last_family_disc_next = last_family_disc;
    last_device_seen_next = last_device_seen;
    bit_position_next     = bit_position;
    last_zero_pos_next    = last_zero_pos;
    pass_active_next      = pass_active;
    wv    = 1'b0;
    wb    = 1'b0;
    done  = 1'b0;
    found = 1'b0;
    dir   = 1'b0;
    pos   = bit_position;
    sh    = 6'(bit_position - 7'd1);
    case (func)
      owse_pkg::FUNC_START: begin
        if (last_device_seen || !in_item.presence) begin
          pass_active_next      = 1'b0;
          done                  = 1'b1;
          last_discrepancy_next = '0;
          last_family_disc_next = '0;
          last_device_seen_next = 1'b0;
        end else begin
          pass_active_next   = 1'b1;
          bit_position_next  = owse_pkg::POS_FIRST;
          last_zero_pos_next = '0;
        end
      end
      owse_pkg::FUNC_PAIR: begin
        if (pass_active) begin
          if (in_item.id_bit && in_item.comp_bit) begin
            // no device answered this bit
            pass_active_next      = 1'b0;
            done                  = 1'b1;
            last_discrepancy_next = '0;
            last_family_disc_next = '0;
            last_device_seen_next = 1'b0;
          end else begin
            if (in_item.id_bit != in_item.comp_bit) begin
              dir = in_item.id_bit;
            end else begin
              // discrepancy: follow previous path, take 1 at the last fork
              if (pos < last_discrepancy) dir = id_register[sh];
              else                        dir = (pos == last_discrepancy);
              if (!dir) begin
                last_zero_pos_next = pos;
                if (pos < owse_pkg::POS_FAMILY) last_family_disc_next = pos[3:0];
              end
            end
            id_register_next[sh] = dir;
            wv                = 1'b1;
            wb                = dir;
            bit_position_next = pos + 7'd1;
            if (bit_position_next >= owse_pkg::POS_END) begin
              pass_active_next      = 1'b0;
              done                  = 1'b1;
              last_discrepancy_next = last_zero_pos_next;
              if (last_zero_pos_next == '0) last_device_seen_next = 1'b1;
              found = 1'b1;
              if (id_register_next[7:0] == 8'd0) begin
                // zero family byte is not a valid device
                last_discrepancy_next = '0;
                last_family_disc_next = '0;
                last_device_seen_next = 1'b0;
                found                 = 1'b0;
              end
            end
          end
        end
      end
      owse_pkg::FUNC_RESET: begin
        pass_active_next      = 1'b0;
        last_discrepancy_next = '0;
        last_family_disc_next = '0;
        last_device_seen_next = 1'b0;
        id_register_next      = '0;
      end
      owse_pkg::FUNC_TARGET: begin
        pass_active_next      = 1'b0;
        id_register_next      = {56'b0, in_item.family_code};
        last_discrepancy_next = owse_pkg::TARGET_DISC;
        last_family_disc_next = '0;
        last_device_seen_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.write_valid        = wv;
    res.write_bit          = wb;
    res.pass_done          = done;
    res.found              = found;
    res.last_device        = last_device_seen_next;
    res.device_id          = id_register_next;
    res.family_discrepancy = last_family_disc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_register      <= '0;
      last_discrepancy <= '0;
      last_family_disc <= '0;
      last_device_seen <= 1'b0;
      bit_position     <= owse_pkg::POS_FIRST;
      last_zero_pos    <= '0;
      pass_active      <= 1'b0;
    end else if (acc) begin
      id_register      <= id_register_next;
      last_discrepancy <= last_discrepancy_next;
      last_family_disc <= last_family_disc_next;
      last_device_seen <= last_device_seen_next;
      bit_position     <= bit_position_next;
      last_zero_pos    <= last_zero_pos_next;
      pass_active      <= pass_active_next;
    end
  end

  // output register with skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= acc;
      end
    end else if (acc) begin
      if (!out_valid) out_valid  <= 1'b1;
      else            skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) out_reg <= skid_reg;
      else            out_reg <= res;
    end else if (acc) begin
      if (!out_valid) out_reg  <= res;
      else            skid_reg <= res;
    end
  end

  `OWSE_ASSERT(a_skid_behind_out, clk, rst, skid_valid |-> out_valid, "skid full with output empty")
  `OWSE_ASSERT(a_skid_blocks_input, clk, rst, skid_valid |-> !s_tready, "input open with skid full")
  `OWSE_ASSERT(a_pos_in_pass, clk, rst, pass_active |-> (bit_position >= 7'd1 && bit_position <= 7'd64), "bit position out of range in pass")
  `OWSE_ASSERT(a_reset_search, clk, rst, (acc && func == owse_pkg::FUNC_RESET) |=> (id_register == '0 && !pass_active && last_discrepancy == '0), "reset search left state")

endmodule

`default_nettype wire
